// ----- rtl/spq_pkg.sv -----
// Package with shared widths, codes and controller/datapath interface types.
package spq_pkg;

    localparam int PRI_W       = 16;
    localparam int ID_W        = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int DEPTH_DEF   = 16;

    // Input tdata: priority_req, process_id.
    localparam int IN_TDATA_W  = 32;
    // Output tdata: served_id, served_priority, entry_count, zero pad.
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - PRI_W - COUNT_OUT_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_EXEC   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_INSERT,
        OP_REMOVE,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY
    } t_op;

    typedef struct packed {
        logic capture;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic req_exec;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

// ----- rtl/spq_datapath.sv -----
// Datapath: request register, sorted compare-and-shift cell row and result register.
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_dp_cmd                  i_cmd,
    output spq_pkg::t_dp_stat                 o_stat,
    input  logic                              i_req_type,
    input  logic signed [spq_pkg::PRI_W-1:0]  i_priority_req,
    input  logic [spq_pkg::ID_W-1:0]          i_process_id,
    output logic [spq_pkg::STATUS_W-1:0]      o_status,
    output logic [spq_pkg::ID_W-1:0]          o_served_id,
    output logic signed [spq_pkg::PRI_W-1:0]  o_served_priority,
    output logic [spq_pkg::COUNT_OUT_W-1:0]   o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                             r_req_type;
    logic signed [spq_pkg::PRI_W-1:0] r_key;
    logic [spq_pkg::ID_W-1:0]         r_pid;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;

    logic signed [spq_pkg::PRI_W-1:0] r_pri [DEPTH];
    logic [spq_pkg::ID_W-1:0]         r_id  [DEPTH];

    logic [spq_pkg::STATUS_W-1:0]     r_res_status;
    logic [spq_pkg::ID_W-1:0]         r_res_id;
    logic signed [spq_pkg::PRI_W-1:0] r_res_pri;
    logic [CW-1:0]                    r_res_count;

    // le[k]: cell k holds a queued entry that stays ahead of the new one.
    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] le_prev;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_key      <= i_priority_req;
            r_pid      <= i_process_id;
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k] = (CW'(k) < r_count) && (r_pri[k] <= r_key);
        end
        le_prev = {le[DEPTH-2:0], 1'b1};
    end

    // Each cell looks only at itself, its neighbors and the key. Since the row is
    // sorted, le is a run of ones from cell 0, so the new entry lands at the first zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [spq_pkg::PRI_W-1:0] w_up_pri;
        logic [spq_pkg::ID_W-1:0]         w_up_id;
        logic signed [spq_pkg::PRI_W-1:0] w_dn_pri;
        logic [spq_pkg::ID_W-1:0]         w_dn_id;

        if (g == 0) begin : g_first
            assign w_dn_pri = r_key;
            assign w_dn_id  = r_pid;
        end else begin : g_inner
            assign w_dn_pri = r_pri[g-1];
            assign w_dn_id  = r_id[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_up_pri = r_pri[g];
            assign w_up_id  = r_id[g];
        end else begin : g_body
            assign w_up_pri = r_pri[g+1];
            assign w_up_id  = r_id[g+1];
        end

        always_ff @(posedge i_clk) begin
            case (i_cmd.op)
                spq_pkg::OP_INSERT: begin
                    if (!le[g]) begin
                        if (le_prev[g]) begin
                            r_pri[g] <= r_key;
                            r_id[g]  <= r_pid;
                        end else begin
                            r_pri[g] <= w_dn_pri;
                            r_id[g]  <= w_dn_id;
                        end
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    r_pri[g] <= w_up_pri;
                    r_id[g]  <= w_up_id;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.op)
            spq_pkg::OP_INSERT: n_count = r_count + CW'(1);
            spq_pkg::OP_REMOVE: n_count = r_count - CW'(1);
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op != spq_pkg::OP_IDLE) begin
            r_res_count <= n_count;
            case (i_cmd.op)
                spq_pkg::OP_REMOVE: begin
                    r_res_status <= spq_pkg::ST_OK;
                    r_res_id     <= r_id[0];
                    r_res_pri    <= r_pri[0];
                end
                spq_pkg::OP_REJECT_FULL: begin
                    r_res_status <= spq_pkg::ST_FULL;
                    r_res_id     <= '0;
                    r_res_pri    <= '0;
                end
                spq_pkg::OP_REJECT_EMPTY: begin
                    r_res_status <= spq_pkg::ST_UNDERFLOW;
                    r_res_id     <= '0;
                    r_res_pri    <= '0;
                end
                default: begin
                    r_res_status <= spq_pkg::ST_OK;
                    r_res_id     <= '0;
                    r_res_pri    <= '0;
                end
            endcase
        end
    end

    assign o_stat.req_exec = (r_req_type == spq_pkg::REQ_EXEC);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));

    assign o_status          = r_res_status;
    assign o_served_id       = r_res_id;
    assign o_served_priority = r_res_pri;
    assign o_entry_count     = spq_pkg::COUNT_OUT_W'(r_res_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == spq_pkg::OP_INSERT |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count by one");

    a_remove_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == spq_pkg::OP_REMOVE |=> r_res_id == $past(r_id[0]))
        else $error("served id is not the previous head");

    a_no_overflow_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == spq_pkg::OP_INSERT |-> !o_stat.full)
        else $error("insert issued into a full queue");

endmodule

// ----- rtl/spq_ctrl.sv -----
// Controller: request sequencing, operation selection and output word valid.
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;

    // A held request commits once the output register is free or being emptied.
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.op      = spq_pkg::OP_IDLE;
        if (w_commit) begin
            if (i_stat.req_exec) begin
                o_cmd.op = i_stat.empty ? spq_pkg::OP_REJECT_EMPTY : spq_pkg::OP_REMOVE;
            end else begin
                o_cmd.op = i_stat.full ? spq_pkg::OP_REJECT_FULL : spq_pkg::OP_INSERT;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op != spq_pkg::OP_IDLE |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an untaken output word");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op != spq_pkg::OP_IDLE |=> r_out_valid && r_state == S_IDLE)
        else $error("commit did not present a result word");

    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_EXEC && !o_in_ready)
        else $error("accepted word not held for execution");

endmodule

// ----- rtl/stable_priority_queue_core.sv -----
// Top level of the stable sorted priority queue: controller plus cell-row datapath.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | priority_req[15:0], process_id[31:16]           | req_type
//  m_axis   | out | served_id[15:0], served_priority[31:16],        | status[1:0]
//           |     | entry_count[36:32], zero pad [39:37]            |
//
// Each request is first captured into the request register; then the cell row
// compares every cell against the key and shifts in place. The output register lets
// the next word be accepted while a result waits; a request stalls in execution
// only while that register is still full. Reset empties the queue.
module stable_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // priority_req [15:0], process_id [31:16]
    input  logic [spq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type [0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // served_id [15:0], served_priority [31:16], entry_count [36:32], zeros above
    output logic [spq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [spq_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    spq_pkg::t_dp_cmd                  w_cmd;
    spq_pkg::t_dp_stat                 w_stat;
    logic [spq_pkg::ID_W-1:0]          w_served_id;
    logic signed [spq_pkg::PRI_W-1:0]  w_served_pri;
    logic [spq_pkg::COUNT_OUT_W-1:0]   w_entry_count;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_req_type        (i_s_axis_tuser),
        .i_priority_req    ($signed(i_s_axis_tdata[spq_pkg::PRI_W-1:0])),
        .i_process_id      (i_s_axis_tdata[spq_pkg::PRI_W +: spq_pkg::ID_W]),
        .o_status          (o_m_axis_tuser),
        .o_served_id       (w_served_id),
        .o_served_priority (w_served_pri),
        .o_entry_count     (w_entry_count)
    );

    assign o_m_axis_tdata = {{spq_pkg::OUT_PAD_W{1'b0}}, w_entry_count,
                             w_served_pri, w_served_id};

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the stable sorted priority queue core.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 382;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        served_id;
        logic signed [PRI_W-1:0] served_pri;
        logic [COUNT_OUT_W-1:0] entry_count;
    } queue_result_t;

    // Tracks the sorted contents of the queue and the results still owed by the block.
    class queue_tracker;
        logic signed [PRI_W-1:0] slot_pri [QUEUE_DEPTH];
        logic [ID_W-1:0]         slot_pid [QUEUE_DEPTH];
        int                      count;
        int                      errors;
        queue_result_t           owed_results [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void note_request(logic req, logic signed [PRI_W-1:0] pri,
                                   logic [ID_W-1:0] pid);
            queue_result_t r;
            int pos;
            int k;
            r.status      = ST_OK;
            r.served_id   = '0;
            r.served_pri  = '0;
            if (req == REQ_INSERT) begin
                if (count >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // The new entry goes behind every entry of equal or smaller priority.
                    pos = 0;
                    while (pos < count && slot_pri[pos] <= pri)
                        pos++;
                    for (k = count; k > pos; k--) begin
                        slot_pri[k] = slot_pri[k-1];
                        slot_pid[k] = slot_pid[k-1];
                    end
                    slot_pri[pos] = pri;
                    slot_pid[pos] = pid;
                    count++;
                end
            end else begin
                if (count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.served_id  = slot_pid[0];
                    r.served_pri = slot_pri[0];
                    for (k = 1; k < count; k++) begin
                        slot_pri[k-1] = slot_pri[k];
                        slot_pid[k-1] = slot_pid[k];
                    end
                    count--;
                end
            end
            r.entry_count = COUNT_OUT_W'(count);
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic [STATUS_W-1:0] user);
            queue_result_t e;
            if (owed_results.size() == 0) begin
                $error("result word with none expected: tdata %h tuser %h", data, user);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            compare_field("status", int'(e.status), int'(user));
            compare_field("served_id", int'(e.served_id), int'(data[15:0]));
            compare_field("served_priority", int'(e.served_pri), int'($signed(data[31:16])));
            compare_field("entry_count", int'(e.entry_count), int'(data[36:32]));
            compare_field("pad", 0, int'(data[OUT_TDATA_W-1:37]));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_valid;
    logic [IN_TDATA_W-1:0]   s_data;
    logic                    s_user;
    logic                    m_ready = 1'b0;
    wire                     s_ready;
    wire                     m_valid;
    wire [OUT_TDATA_W-1:0]   m_data;
    wire [STATUS_W-1:0]      m_user;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    queue_tracker sb = new();

    stable_priority_queue_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            sb.check_result(m_data, m_user);
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Starts and ends on a falling edge; the request is logged at the accepting edge.
    task automatic send_word(input logic req, input logic [PRI_W-1:0] pri,
                             input logic [ID_W-1:0] pid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge clk);
        end
        s_valid = 1'b1;
        s_user  = req;
        s_data  = {pid, pri};
        do @(posedge clk); while (!s_ready);
        sb.note_request(req, pri, pid);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [PRI_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return PRI_W'($urandom);
        else if (sel < 80)
            // A narrow band makes ties common, which exercises arrival order.
            return PRI_W'(int'($urandom_range(6)) - 3);
        else
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
    endfunction

    task automatic run_random(input int n_items);
        int insert_pct;
        int i;
        insert_pct = 50;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            if ($urandom_range(99) < insert_pct)
                send_word(REQ_INSERT, pick_priority(), ID_W'($urandom));
            else
                send_word(REQ_EXEC, PRI_W'($urandom), ID_W'($urandom));
        end
    endtask

    initial begin
        int k;
        int ph;
        rst_n   = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = REQ_INSERT;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty execute, extreme values, ties, filling up and a refused insert.
        send_word(REQ_EXEC, 16'h1234, 16'h5678);
        send_word(REQ_INSERT, 16'd5, 16'h0001);
        send_word(REQ_INSERT, 16'h8000, 16'hffff);
        send_word(REQ_INSERT, 16'h7fff, 16'h0000);
        send_word(REQ_INSERT, 16'd5, 16'h0002);
        send_word(REQ_INSERT, 16'd5, 16'h0003);
        send_word(REQ_INSERT, 16'h0000, 16'haaaa);
        send_word(REQ_INSERT, 16'hffff, 16'h5555);
        send_word(REQ_INSERT, 16'h8000, 16'h8000);
        send_word(REQ_INSERT, 16'h7fff, 16'h7fff);
        for (k = 9; k < QUEUE_DEPTH; k++)
            send_word(REQ_INSERT, PRI_W'(5 - k % 3), ID_W'(16'h1000 + k));
        send_word(REQ_INSERT, 16'h8000, 16'hbeef);
        for (k = 0; k < 4; k++)
            send_word(REQ_EXEC, 16'h0000, 16'h0000);
        send_word(REQ_INSERT, 16'hffff, 16'hffff);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            run_random(PHASE_ITEMS);
            // Hold the sender back until every owed result has come out.
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
